// File: hdl/hce_pkg.sv
// shared constants, types and helpers for the chunked body encoder
package hce_pkg;

    localparam int HCE_LEN_BITS    = 16;
    localparam int HCE_HEX_DIGITS  = (HCE_LEN_BITS + 3) / 4;
    localparam int HCE_HEX_W       = HCE_HEX_DIGITS * 4;
    localparam int HCE_MAX_RESULTS = HCE_HEX_DIGITS + 5;
    localparam int HCE_CNT_W       = $clog2(HCE_MAX_RESULTS + 1);
    localparam int HCE_CALC_W      = (HCE_LEN_BITS > 16) ? HCE_LEN_BITS : 16;

    typedef logic [HCE_LEN_BITS-1:0] hce_len_t;
    typedef logic [HCE_CALC_W-1:0]   hce_calc_t;
    typedef logic [HCE_HEX_W-1:0]    hce_hex_t;
    typedef logic [HCE_CNT_W-1:0]    hce_cnt_t;
    typedef logic [1:0]              hce_phase_t;

    localparam hce_calc_t HCE_LEN_MAX = hce_calc_t'((64'd1 << HCE_LEN_BITS) - 64'd1);

    // phase codes
    localparam hce_phase_t PH_IDLE = 2'd0;
    localparam hce_phase_t PH_BODY = 2'd1;
    localparam hce_phase_t PH_DONE = 2'd2;

    // action codes
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    localparam logic [15:0] CHUNK_SIZE_RESET = 16'd512;

    typedef struct packed {
        logic [HCE_MAX_RESULTS-1:0][7:0] bytes;
        hce_cnt_t                        count;
        logic                            done;
    } hce_frame_t;

    // lowercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = 8'h30 + {4'h0, d};
        else
            c = 8'h57 + {4'h0, d};
        return c;
    endfunction

endpackage

// File: hdl/hce_in_if.sv
// body word channel: action, data byte and ready count
interface hce_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  data_byte;
    logic [15:0] ready_count;

    modport source (output valid, output action, output data_byte, output ready_count,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input ready_count,
                    output ready);
endinterface

// File: hdl/hce_out_if.sv
// encoded stream channel: one output byte per word
interface hce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    output ready);
endinterface

// File: hdl/hce_framer.sv
// chunk state and framing of one body word into its encoded bytes
module hce_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                action,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         ready_count,
    input  logic [15:0]         chunk_size,
    output hce_pkg::hce_frame_t frame
);

    hce_pkg::hce_phase_t phase_reg, phase_next;
    hce_pkg::hce_len_t   bytes_left_reg, bytes_left_next;

    logic                start;
    logic [15:0]         cs_eff;
    logic [15:0]         rc_eff;
    logic [15:0]         len16;
    hce_pkg::hce_calc_t  len_calc;
    hce_pkg::hce_len_t   len;
    hce_pkg::hce_hex_t   len_hex;
    hce_pkg::hce_cnt_t   ndig;
    hce_pkg::hce_cnt_t   hdr;
    hce_pkg::hce_cnt_t   pos;
    hce_pkg::hce_cnt_t   nib_idx;
    hce_pkg::hce_len_t   left_cur;
    hce_pkg::hce_len_t   left_dec;
    logic                close;

    always_comb
    begin
        start  = (phase_reg == hce_pkg::PH_IDLE) && (action == hce_pkg::ACT_DATA);
        cs_eff = (chunk_size == 16'd0) ? 16'd1 : chunk_size;
        rc_eff = (ready_count == 16'd0) ? 16'd1 : ready_count;
        len16  = (rc_eff < cs_eff) ? rc_eff : cs_eff;
        len_calc = hce_pkg::hce_calc_t'(len16);
        if (len_calc > hce_pkg::HCE_LEN_MAX)
            len_calc = hce_pkg::HCE_LEN_MAX;
        len     = hce_pkg::hce_len_t'(len_calc);
        len_hex = hce_pkg::hce_hex_t'(len);

        // hex digits without leading zeros, at least one
        ndig = hce_pkg::hce_cnt_t'(1);
        for (int j = 0; j < hce_pkg::HCE_HEX_DIGITS; j++)
        begin
            if (len_hex[j*4 +: 4] != 4'h0)
                ndig = hce_pkg::hce_cnt_t'(j + 1);
        end

        left_cur = start ? len : bytes_left_reg;
        left_dec = (left_cur != '0) ? left_cur - hce_pkg::hce_len_t'(1) : left_cur;
        close    = (left_dec == '0);
        hdr      = start ? ndig + hce_pkg::hce_cnt_t'(2) : '0;

        frame       = '0;
        pos         = '0;
        nib_idx     = '0;
        phase_next  = phase_reg;
        bytes_left_next = bytes_left_reg;

        case (phase_reg)
            hce_pkg::PH_IDLE, hce_pkg::PH_BODY:
            begin
                if (action == hce_pkg::ACT_END)
                begin
                    if (phase_reg == hce_pkg::PH_IDLE)
                    begin
                        frame.bytes[0] = hce_pkg::CHAR_ZERO;
                        frame.bytes[1] = hce_pkg::CHAR_CR;
                        frame.bytes[2] = hce_pkg::CHAR_LF;
                        frame.bytes[3] = hce_pkg::CHAR_CR;
                        frame.bytes[4] = hce_pkg::CHAR_LF;
                        frame.count    = hce_pkg::hce_cnt_t'(5);
                        frame.done     = 1'b1;
                        phase_next     = hce_pkg::PH_DONE;
                        bytes_left_next = '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < hce_pkg::HCE_MAX_RESULTS; i++)
                    begin
                        pos     = hce_pkg::hce_cnt_t'(i);
                        nib_idx = ndig - hce_pkg::hce_cnt_t'(1) - pos;
                        if (start && pos < ndig)
                        begin
                            for (int j = 0; j < hce_pkg::HCE_HEX_DIGITS; j++)
                            begin
                                if (nib_idx == hce_pkg::hce_cnt_t'(j))
                                    frame.bytes[i] = hce_pkg::hex_char(len_hex[j*4 +: 4]);
                            end
                        end
                        else if (start && pos == ndig)
                            frame.bytes[i] = hce_pkg::CHAR_CR;
                        else if (start && pos == ndig + hce_pkg::hce_cnt_t'(1))
                            frame.bytes[i] = hce_pkg::CHAR_LF;
                        else if (pos == hdr)
                            frame.bytes[i] = data_byte;
                        else if (pos == hdr + hce_pkg::hce_cnt_t'(1))
                            frame.bytes[i] = hce_pkg::CHAR_CR;
                        else if (pos == hdr + hce_pkg::hce_cnt_t'(2))
                            frame.bytes[i] = hce_pkg::CHAR_LF;
                    end
                    frame.count = hdr + (close ? hce_pkg::hce_cnt_t'(3)
                                               : hce_pkg::hce_cnt_t'(1));
                    bytes_left_next = left_dec;
                    phase_next = close ? hce_pkg::PH_IDLE : hce_pkg::PH_BODY;
                end
            end
            default:
            begin
                // done, and the unused code, give nothing
                frame.count = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hce_pkg::PH_IDLE;
            bytes_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// File: hdl/hce_serializer.sv
// result register that shifts a framed word out one byte at a time
module hce_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hce_pkg::hce_frame_t frame,
    output logic                can_load,
    hce_out_if.source           stream
);

    logic [hce_pkg::HCE_MAX_RESULTS-1:0][7:0] buf_reg;
    hce_pkg::hce_cnt_t                        cnt_reg;
    logic                                     done_reg;
    logic                                     pop;

    assign pop      = stream.valid && stream.ready;
    assign can_load = (cnt_reg == '0)
                   || ((cnt_reg == hce_pkg::hce_cnt_t'(1)) && stream.ready);

    assign stream.valid       = (cnt_reg != '0);
    assign stream.out_byte    = buf_reg[0];
    assign stream.run_last    = (cnt_reg == hce_pkg::hce_cnt_t'(1));
    assign stream.stream_done = done_reg && (cnt_reg == hce_pkg::hce_cnt_t'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg  <= frame.count;
            done_reg <= frame.done;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - hce_pkg::hce_cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= frame.bytes;
        else if (pop)
            buf_reg <= buf_reg >> 8;
    end

endmodule

// File: hdl/http_chunked_body_encoder_unit.sv
// top level of the http/1.1 chunked transfer encoder
// Takes body words (one byte plus the count of bytes the source has ready, or an end
// marker) and produces the chunked byte stream one byte per output word. A body word
// that opens a chunk fixes its length as min(ready_count, chunk_size), with zero of
// either counted as one, and yields the length in lowercase hex, CR LF, the byte, and
// CR LF if the chunk is already complete: up to 9 output words. A body word inside a
// chunk yields its byte, plus CR LF when it closes the chunk. An end word between chunks
// yields "0" CR LF CR LF and flags stream_done on the last LF; an end word inside a
// chunk, and every word after done, yields nothing. run_last marks the last output
// word of each input word. An input word is taken in the same cycle as the last byte
// of the previous one leaves, so in-chunk body bytes stream at one per cycle unless
// the output stalls; a word holds the input until its last byte leaves the single output
// byte register. chunk_size resets to 512 and is to be written while idle, unenforced.
module http_chunked_body_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    hce_in_if.sink      body,
    hce_out_if.source   stream
);

    logic                chunk_wr_ok;
    logic [15:0]         chunk_size_reg;
    logic                can_load;
    logic                accept;
    hce_pkg::hce_frame_t frame;

    // config register, no read-back
    assign chunk_wr_ok = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_size_reg <= hce_pkg::CHUNK_SIZE_RESET;
        else if (chunk_wr_ok)
            chunk_size_reg <= cfg_wdata;
    end

    // input taken when the output register is free or frees up this cycle
    assign body.ready = can_load;
    assign accept     = body.valid && body.ready;

    // framing of the accepted word and the chunk state
    hce_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (body.action),
        .data_byte   (body.data_byte),
        .ready_count (body.ready_count),
        .chunk_size  (chunk_size_reg),
        .frame       (frame)
    );

    // output register and byte shifter
    hce_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .frame    (frame),
        .can_load (can_load),
        .stream   (stream)
    );

endmodule

// File: hdl/hce_checker.sv
// port-level checker for the chunked encoder, bound to the top level
module hce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       body_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       stream_done
);

    logic done_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_seen_reg <= 1'b0;
        else if (out_valid && out_ready && stream_done)
            done_seen_reg <= 1'b1;
    end

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_done) |-> (run_last && out_byte == 8'h0a))
        else $error("stream_done not on a final lf");

    a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_seen_reg |-> !out_valid)
        else $error("output after the terminating chunk");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> body_ready)
        else $error("input stalled with empty output");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
        else $error("stalled output word changed");

endmodule

bind http_chunked_body_encoder_unit hce_checker u_hce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .body_ready  (body.ready),
    .out_valid   (stream.valid),
    .out_ready   (stream.ready),
    .out_byte    (stream.out_byte),
    .run_last    (stream.run_last),
    .stream_done (stream.stream_done)
);
